// File: rtl/mks_pkg.sv
// shared constants and word types for the matrix keypad scanner
// no dependencies; imported by matrix_keypad_scanner
`default_nettype none

package mks_pkg;

  localparam int ROWS   = 6;
  localparam int COLS   = 4;
  localparam int NKEYS  = COLS * ROWS;
  localparam int LINES  = (COLS > ROWS) ? COLS : ROWS;

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int LINE_W = $clog2(LINES);
  localparam int NCOL_W = $clog2(COLS + 1);
  localparam int NROW_W = $clog2(ROWS + 1);

  // field widths of the result word
  localparam int KEY_W  = 5;
  localparam int HELD_W = 5;

  typedef struct packed {
    logic [COLS-1:0] col_active;
    logic [ROWS-1:0] row_active;
    logic            probe_level;
  } in_t;

  typedef struct packed {
    logic              has_event;
    logic [KEY_W-1:0]  key_index;
    logic              key_down;
    logic [HELD_W-1:0] keys_held;
    logic              last;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/matrix_keypad_scanner.sv
// matrix keypad scanner: line analysis, ghost removal and serial key walk
// depends on mks_pkg for widths and word types
// sequence: line analysis over every column and row line, an evaluation step,
// then a walk over all NKEYS keys, one key per cycle unless a found change waits
// on a stalled output, and a closing step; a rejected scan ends at evaluation
// throughput: one scan at a time; in_ready rises with the same edge that registers
// the last word, so a new scan is not taken before the last one is done
// synchronous active-low reset clears the stored key state to all released
`default_nettype none

module matrix_keypad_scanner (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mks_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mks_pkg::out_t      out_data
);
  import mks_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [NKEYS-1:0]  rep_r, rep_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [KEY_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              pend_down_r, pend_down_nxt;

  // line analysis shift registers
  logic [COLS-1:0]   scan_col_r, scan_col_nxt;
  logic [ROWS-1:0]   scan_row_r, scan_row_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [NCOL_W-1:0] ncol_r, ncol_nxt;
  logic [NROW_W-1:0] nrow_r, nrow_nxt;
  logic [COL_W-1:0]  ci0_r, ci0_nxt, ci1_r, ci1_nxt;
  logic [ROW_W-1:0]  ri0_r, ri0_nxt, ri1_r, ri1_nxt;
  logic              probe_r, probe_nxt;
  logic              ghost_r, ghost_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;

  // key walk
  logic [COLS-1:0]   walk_col_r, walk_col_nxt;
  logic [ROWS-1:0]   walk_row_r, walk_row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;

  logic out_free;
  logic accept_scan;
  logic ghost_key;
  logic seen;
  logic diff;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign accept_scan = (nrow_r == NROW_W'(1)) || (ncol_r == NCOL_W'(1)) ||
                       (ncol_r == '0) ||
                       ((nrow_r == NROW_W'(2)) && (ncol_r == NCOL_W'(2)));

  always_comb begin
    ghost_key = 1'b0;
    if (ghost_r) begin
      if (!probe_r) begin
        ghost_key = ((col_r == ci0_r) && (row_r == ri0_r)) ||
                    ((col_r == ci1_r) && (row_r == ri1_r));
      end else begin
        ghost_key = ((col_r == ci1_r) && (row_r == ri0_r)) ||
                    ((col_r == ci0_r) && (row_r == ri1_r));
      end
    end
  end

  assign seen = walk_col_r[0] && walk_row_r[0] && !ghost_key;
  assign diff = seen ^ rep_r[0];

  always_comb begin
    state_nxt      = state_r;
    rep_nxt        = rep_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_down_nxt  = pend_down_r;
    scan_col_nxt   = scan_col_r;
    scan_row_nxt   = scan_row_r;
    line_nxt       = line_r;
    ncol_nxt       = ncol_r;
    nrow_nxt       = nrow_r;
    ci0_nxt        = ci0_r;
    ci1_nxt        = ci1_r;
    ri0_nxt        = ri0_r;
    ri1_nxt        = ri1_r;
    probe_nxt      = probe_r;
    ghost_nxt      = ghost_r;
    held_nxt       = held_r;
    walk_col_nxt   = walk_col_r;
    walk_row_nxt   = walk_row_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    key_nxt        = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          scan_col_nxt = in_data.col_active;
          // rows only count with some column active
          scan_row_nxt = (in_data.col_active == '0) ? '0 : in_data.row_active;
          walk_col_nxt = in_data.col_active;
          walk_row_nxt = in_data.row_active;
          probe_nxt    = in_data.probe_level;
          line_nxt     = '0;
          ncol_nxt     = '0;
          nrow_nxt     = '0;
          ci0_nxt      = '0;
          ci1_nxt      = '0;
          ri0_nxt      = '0;
          ri1_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        // one column line and one row line per cycle
        if (scan_col_r[0]) begin
          if (ncol_r == '0) begin
            ci0_nxt = line_r[COL_W-1:0];
          end else if (ncol_r == NCOL_W'(1)) begin
            ci1_nxt = line_r[COL_W-1:0];
          end
          ncol_nxt = ncol_r + NCOL_W'(1);
        end
        if (scan_row_r[0]) begin
          if (nrow_r == '0) begin
            ri0_nxt = line_r[ROW_W-1:0];
          end else if (nrow_r == NROW_W'(1)) begin
            ri1_nxt = line_r[ROW_W-1:0];
          end
          nrow_nxt = nrow_r + NROW_W'(1);
        end
        scan_col_nxt = scan_col_r >> 1;
        scan_row_nxt = scan_row_r >> 1;
        line_nxt     = line_r + LINE_W'(1);
        if (line_r == LINE_W'(LINES - 1)) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        ghost_nxt = (ncol_r == NCOL_W'(2)) && (nrow_r == NROW_W'(2));
        priority if (nrow_r == NROW_W'(1)) begin
          held_nxt = HELD_W'(ncol_r);
        end else if (ncol_r == NCOL_W'(1)) begin
          held_nxt = HELD_W'(nrow_r);
        end else if (ncol_r == '0) begin
          held_nxt = '0;
        end else begin
          // two by two less the ghost pair
          held_nxt = HELD_W'(2);
        end
        col_nxt        = '0;
        row_nxt        = '0;
        key_nxt        = '0;
        pend_valid_nxt = 1'b0;
        if (!accept_scan) begin
          if (out_free) begin
            out_nxt       = '{has_event: 1'b0, key_index: '0, key_down: 1'b0,
                              keys_held: '0, last: 1'b1};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        // a found change waits in the pending slot until the next one proves it not last
        if (!diff || !pend_valid_r || out_free) begin
          rep_nxt      = {seen, rep_r[NKEYS-1:1]};
          walk_row_nxt = {walk_row_r[0], walk_row_r[ROWS-1:1]};
          if (diff) begin
            if (pend_valid_r) begin
              out_nxt       = '{has_event: 1'b1, key_index: pend_idx_r,
                                key_down: pend_down_r, keys_held: held_r,
                                last: 1'b0};
              out_valid_nxt = 1'b1;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = key_r;
            pend_down_nxt  = seen;
          end
          key_nxt = key_r + KEY_W'(1);
          if (row_r == ROW_W'(ROWS - 1)) begin
            row_nxt      = '0;
            col_nxt      = col_r + COL_W'(1);
            walk_col_nxt = walk_col_r >> 1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
          if (key_r == KEY_W'(NKEYS - 1)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          if (pend_valid_r) begin
            out_nxt = '{has_event: 1'b1, key_index: pend_idx_r,
                        key_down: pend_down_r, keys_held: held_r, last: 1'b1};
          end else begin
            out_nxt = '{has_event: 1'b0, key_index: '0, key_down: 1'b0,
                        keys_held: held_r, last: 1'b1};
          end
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rep_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rep_r        <= rep_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_down_r <= pend_down_nxt;
    scan_col_r  <= scan_col_nxt;
    scan_row_r  <= scan_row_nxt;
    line_r      <= line_nxt;
    ncol_r      <= ncol_nxt;
    nrow_r      <= nrow_nxt;
    ci0_r       <= ci0_nxt;
    ci1_r       <= ci1_nxt;
    ri0_r       <= ri0_nxt;
    ri1_r       <= ri1_nxt;
    probe_r     <= probe_nxt;
    ghost_r     <= ghost_nxt;
    held_r      <= held_nxt;
    walk_col_r  <= walk_col_nxt;
    walk_row_r  <= walk_row_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    key_r       <= key_nxt;
  end

endmodule

`default_nettype wire
